/* hdl/ride_stats_accumulator_macros.svh */
// Assertion helpers shared by the ride statistics RTL.
`ifndef RIDE_STATS_ACCUMULATOR_MACROS_SVH
`define RIDE_STATS_ACCUMULATOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RSA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: ante -> cons");
// next-cycle implication
`define RSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante => cons");
`else
`define RSA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define RSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/rsa_pkg.sv */
package rsa_pkg;

    // rolling window for normalized power
    localparam int WINDOW_LEN = 30;
    localparam int HALF_LEN   = WINDOW_LEN / 2;
    localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
    localparam int POWER_W    = 12;
    localparam int POWER_MAX  = (1 << POWER_W) - 1;
    // window sum plus rounding offset
    localparam int TOT_W      = $clog2(WINDOW_LEN * POWER_MAX + HALF_LEN + 1);
    // serial divider remainder
    localparam int REM_W      = $clog2(WINDOW_LEN);
    // average and its square
    localparam int AVG_W      = POWER_W;
    localparam int SQ_W       = 2 * AVG_W;
    localparam int TERM_W     = 2 * SQ_W;
    localparam int CNT_W      = $clog2(SQ_W + 1);

    // field widths
    localparam int SPEED_W    = 11;
    localparam int HYST_W     = 10;
    localparam int HR_W       = 8;
    localparam int ELEV_W     = 18;
    localparam int CFG_DATA_W = 11;

    // configuration register indexes
    localparam logic CFG_MOVE_THR   = 1'b0;
    localparam logic CFG_CLIMB_HYST = 1'b1;

    localparam logic [HR_W-1:0] HR_ABSENT = 8'hFF;

    // status from the fourth-power engine
    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_status;

endpackage

/* hdl/rsa_window.sv */
module rsa_window (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic                            i_clear,
    input  logic [rsa_pkg::POWER_W-1:0]     i_power,
    output logic [rsa_pkg::TOT_W-1:0]       o_total,
    output logic                            o_full
);

    logic [rsa_pkg::POWER_W-1:0] r_store [rsa_pkg::WINDOW_LEN];
    logic [rsa_pkg::IDX_W-1:0]   r_head, n_head;
    logic [rsa_pkg::FILL_W-1:0]  r_fill, n_fill;
    logic [rsa_pkg::TOT_W-1:0]   r_total, n_total;
    logic [rsa_pkg::POWER_W-1:0] w_old;
    logic                        w_full;

    assign w_full = (r_fill == rsa_pkg::FILL_W'(rsa_pkg::WINDOW_LEN));
    assign w_old  = w_full ? r_store[r_head] : '0;

    // ring pointer, fill count and running sum
    always_comb begin
        n_head  = r_head;
        n_fill  = r_fill;
        n_total = r_total;
        if (i_clear) begin
            n_head  = '0;
            n_fill  = '0;
            n_total = '0;
        end else if (i_push) begin
            n_total = r_total - rsa_pkg::TOT_W'(w_old) + rsa_pkg::TOT_W'(i_power);
            n_head  = (r_head == rsa_pkg::IDX_W'(rsa_pkg::WINDOW_LEN - 1)) ? '0
                                                                          : r_head + 1'b1;
            if (!w_full) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_fill  <= '0;
            r_total <= '0;
        end else begin
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_total <= n_total;
        end
    end

    // sample store, no reset: read only once written
    always_ff @(posedge i_clk) begin
        if (i_push && !i_clear) begin
            r_store[r_head] <= i_power;
        end
    end

    assign o_total = r_total;
    assign o_full  = w_full;

`include "ride_stats_accumulator_macros.svh"
    `RSA_ASSERT_IMPLIES(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= rsa_pkg::FILL_W'(rsa_pkg::WINDOW_LEN))
    `RSA_ASSERT_IMPLIES(a_head_range, i_clk, i_rst_n, 1'b1, r_head <= rsa_pkg::IDX_W'(rsa_pkg::WINDOW_LEN - 1))
    `RSA_ASSERT_IMPLIES(a_sum_bound, i_clk, i_rst_n, r_fill == '0, r_total == '0)

endmodule

/* hdl/rsa_fourth.sv */
module rsa_fourth (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [rsa_pkg::TOT_W-1:0]       i_total,
    output rsa_pkg::t_eng_status            o_status,
    output logic [rsa_pkg::TERM_W-1:0]      o_term
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SQ1  = 2'd2;
    localparam logic [1:0] S_SQ2  = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [rsa_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [rsa_pkg::TOT_W-1:0]    r_dvd, n_dvd;
    logic [rsa_pkg::REM_W-1:0]    r_rem, n_rem;
    logic [rsa_pkg::SQ_W-1:0]     r_mcand, n_mcand;
    logic [rsa_pkg::SQ_W-1:0]     r_mplier, n_mplier;
    logic [rsa_pkg::TERM_W-1:0]   r_prod, n_prod;

    logic [rsa_pkg::REM_W:0]      w_rem_sh;
    logic                         w_qbit;
    logic [rsa_pkg::REM_W:0]      w_rem_sub;
    logic [rsa_pkg::TOT_W-1:0]    w_quot;
    logic [rsa_pkg::SQ_W:0]       w_sum;
    logic [rsa_pkg::TERM_W-1:0]   w_prod;
    logic                         w_last;
    logic                         w_done;

    // restoring divide by the window length, one quotient bit a cycle
    assign w_rem_sh  = {r_rem, r_dvd[rsa_pkg::TOT_W-1]};
    assign w_qbit    = (w_rem_sh >= (rsa_pkg::REM_W+1)'(rsa_pkg::WINDOW_LEN));
    assign w_rem_sub = w_rem_sh - (rsa_pkg::REM_W+1)'(rsa_pkg::WINDOW_LEN);
    assign w_quot    = {r_dvd[rsa_pkg::TOT_W-2:0], w_qbit};

    // shift-add multiply, one multiplier bit a cycle
    assign w_sum  = {1'b0, r_prod[rsa_pkg::TERM_W-1:rsa_pkg::SQ_W]}
                  + {1'b0, (r_mplier[0] ? r_mcand : {rsa_pkg::SQ_W{1'b0}})};
    assign w_prod = {w_sum, r_prod[rsa_pkg::SQ_W-1:1]};

    assign w_last = (r_cnt == rsa_pkg::CNT_W'(1));

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_dvd    = r_dvd;
        n_rem    = r_rem;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_prod   = r_prod;
        w_done   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_dvd   = i_total + rsa_pkg::TOT_W'(rsa_pkg::HALF_LEN);
                    n_rem   = '0;
                    n_cnt   = rsa_pkg::CNT_W'(rsa_pkg::TOT_W);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_dvd = w_quot;
                n_rem = w_qbit ? w_rem_sub[rsa_pkg::REM_W-1:0] : w_rem_sh[rsa_pkg::REM_W-1:0];
                n_cnt = r_cnt - 1'b1;
                if (w_last) begin
                    n_mcand  = rsa_pkg::SQ_W'(w_quot[rsa_pkg::AVG_W-1:0]);
                    n_mplier = rsa_pkg::SQ_W'(w_quot[rsa_pkg::AVG_W-1:0]);
                    n_prod   = '0;
                    n_cnt    = rsa_pkg::CNT_W'(rsa_pkg::SQ_W);
                    n_state  = S_SQ1;
                end
            end
            S_SQ1: begin
                n_prod   = w_prod;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - 1'b1;
                if (w_last) begin
                    n_mcand  = w_prod[rsa_pkg::SQ_W-1:0];
                    n_mplier = w_prod[rsa_pkg::SQ_W-1:0];
                    n_prod   = '0;
                    n_cnt    = rsa_pkg::CNT_W'(rsa_pkg::SQ_W);
                    n_state  = S_SQ2;
                end
            end
            S_SQ2: begin
                n_prod   = w_prod;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - 1'b1;
                if (w_last) begin
                    w_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_prod   <= n_prod;
    end

    assign o_status.busy = (r_state != S_IDLE);
    assign o_status.done = w_done;
    assign o_term        = w_prod;

`include "ride_stats_accumulator_macros.svh"
    `RSA_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, w_done, r_state == S_IDLE)
    `RSA_ASSERT_IMPLIES(a_done_in_sq2, i_clk, i_rst_n, w_done, r_state == S_SQ2)
    `RSA_ASSERT_IMPLIES(a_cnt_live, i_clk, i_rst_n, r_state != S_IDLE, r_cnt != '0)

endmodule

/* hdl/ride_stats_accumulator.sv */
// Channel   | Handshake                    | Payload
// ----------+------------------------------+------------------------------------------
// sample in | i_in_valid / o_in_stall      | mode, speed, power, heart rate, elevation
// result    | o_out_valid / i_out_stall    | eight ride statistics
// config    | i_cfg_we                     | i_cfg_idx, i_cfg_data
//
// One request at a time: a clear or a request without power reaches the result register
// after the busy register, a power request after the busy and kick registers; with the
// window full it also waits for the bit-serial divider and the two bit-serial squarings.
// Synchronous active-low reset; no clearing pass is needed.
// A new request is taken while a result waits in the output register; the next
// result leaves only after that one is taken.
module ride_stats_accumulator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [rsa_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_mode,
    input  logic [rsa_pkg::SPEED_W-1:0]         i_speed,
    input  logic                                i_power_valid,
    input  logic [rsa_pkg::POWER_W-1:0]         i_power_w,
    input  logic [rsa_pkg::HR_W-1:0]            i_heart_rate,
    input  logic                                i_elevation_valid,
    input  logic signed [rsa_pkg::ELEV_W-1:0]   i_elevation_dm,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [31:0]                         o_moving_seconds,
    output logic [43:0]                         o_power_total,
    output logic [31:0]                         o_power_samples,
    output logic [63:0]                         o_np_fourth_sum,
    output logic [31:0]                         o_np_samples,
    output logic [39:0]                         o_heart_total,
    output logic [31:0]                         o_heart_samples,
    output logic [31:0]                         o_climbed_dm
);

    logic [rsa_pkg::SPEED_W-1:0]  r_move_thr;
    logic [rsa_pkg::HYST_W-1:0]   r_hyst;

    logic [31:0] r_moving;
    logic [43:0] r_pwr_sum;
    logic [31:0] r_pwr_cnt;
    logic [63:0] r_fourth;
    logic [31:0] r_fourth_cnt;
    logic [39:0] r_hr_sum;
    logic [31:0] r_hr_cnt;
    logic [31:0] r_climb;
    logic signed [rsa_pkg::ELEV_W-1:0] r_base;
    logic        r_base_valid;

    logic r_busy;
    logic r_kick;
    logic r_out_valid;

    logic w_acc, w_tick, w_clear, w_push, w_start, w_publish, w_slot_free;
    logic [rsa_pkg::TOT_W-1:0]  w_total;
    logic                       w_full;
    rsa_pkg::t_eng_status       w_eng;
    logic [rsa_pkg::TERM_W-1:0] w_term;

    assign w_acc   = i_in_valid && !o_in_stall;
    assign w_tick  = w_acc && !i_mode;
    assign w_clear = w_acc && i_mode;
    assign w_push  = w_tick && i_power_valid;
    assign o_in_stall = r_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_thr <= rsa_pkg::SPEED_W'(30);
            r_hyst     <= rsa_pkg::HYST_W'(30);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rsa_pkg::CFG_MOVE_THR:   r_move_thr <= i_cfg_data[rsa_pkg::SPEED_W-1:0];
                rsa_pkg::CFG_CLIMB_HYST: r_hyst     <= i_cfg_data[rsa_pkg::HYST_W-1:0];
                default: ;
            endcase
        end
    end

    rsa_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_clear (w_clear),
        .i_power (i_power_w),
        .o_total (w_total),
        .o_full  (w_full)
    );

    assign w_start = r_kick && w_full;

    rsa_fourth u_fourth (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_total  (w_total),
        .o_status (w_eng),
        .o_term   (w_term)
    );

    // saturating sums
    logic [32:0] w_mov_inc, w_pcnt_inc, w_fcnt_inc, w_hcnt_inc, w_climb_add;
    logic [44:0] w_psum_add;
    logic [40:0] w_hsum_add;
    logic [64:0] w_fourth_add;

    assign w_mov_inc    = {1'b0, r_moving} + 33'd1;
    assign w_pcnt_inc   = {1'b0, r_pwr_cnt} + 33'd1;
    assign w_fcnt_inc   = {1'b0, r_fourth_cnt} + 33'd1;
    assign w_hcnt_inc   = {1'b0, r_hr_cnt} + 33'd1;
    assign w_psum_add   = {1'b0, r_pwr_sum} + 45'(i_power_w);
    assign w_hsum_add   = {1'b0, r_hr_sum} + 41'(i_heart_rate);
    assign w_fourth_add = {1'b0, r_fourth} + 65'(w_term);

    // climb with hysteresis band
    logic signed [rsa_pkg::ELEV_W+1:0] w_elev, w_base, w_band, w_diff;
    logic w_up, w_down;

    assign w_elev = (rsa_pkg::ELEV_W+2)'(i_elevation_dm);
    assign w_base = (rsa_pkg::ELEV_W+2)'(r_base);
    assign w_band = $signed({{(rsa_pkg::ELEV_W+2-rsa_pkg::HYST_W){1'b0}}, r_hyst});
    assign w_diff = w_elev - w_base;
    assign w_up   = w_elev > (w_base + w_band);
    assign w_down = w_elev < (w_base - w_band);
    assign w_climb_add = {1'b0, r_climb} + 33'(w_diff[rsa_pkg::ELEV_W:0]);

    // statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_moving     <= '0;
            r_pwr_sum    <= '0;
            r_pwr_cnt    <= '0;
            r_fourth     <= '0;
            r_fourth_cnt <= '0;
            r_hr_sum     <= '0;
            r_hr_cnt     <= '0;
            r_climb      <= '0;
            r_base       <= '0;
            r_base_valid <= 1'b0;
        end else begin
            if (w_tick && (i_speed > r_move_thr)) begin
                r_moving <= w_mov_inc[32] ? '1 : w_mov_inc[31:0];
            end
            if (w_push) begin
                r_pwr_sum <= w_psum_add[44] ? '1 : w_psum_add[43:0];
                r_pwr_cnt <= w_pcnt_inc[32] ? '1 : w_pcnt_inc[31:0];
            end
            if (w_tick && (i_heart_rate != rsa_pkg::HR_ABSENT)) begin
                r_hr_sum <= w_hsum_add[40] ? '1 : w_hsum_add[39:0];
                r_hr_cnt <= w_hcnt_inc[32] ? '1 : w_hcnt_inc[31:0];
            end
            if (w_eng.done) begin
                r_fourth     <= w_fourth_add[64] ? '1 : w_fourth_add[63:0];
                r_fourth_cnt <= w_fcnt_inc[32] ? '1 : w_fcnt_inc[31:0];
            end
            if (w_tick && i_elevation_valid) begin
                if (!r_base_valid) begin
                    r_base       <= i_elevation_dm;
                    r_base_valid <= 1'b1;
                end else if (w_up) begin
                    r_climb <= w_climb_add[32] ? '1 : w_climb_add[31:0];
                    r_base  <= i_elevation_dm;
                end else if (w_down) begin
                    r_base  <= i_elevation_dm;
                end
            end
        end
    end

    // request control and result register
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_publish   = r_busy && !r_kick && !w_eng.busy && w_slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_kick      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_kick <= w_push;
            if (w_acc) begin
                r_busy <= 1'b1;
            end else if (w_publish) begin
                r_busy <= 1'b0;
            end
            if (w_publish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_publish) begin
            o_moving_seconds <= r_moving;
            o_power_total    <= r_pwr_sum;
            o_power_samples  <= r_pwr_cnt;
            o_np_fourth_sum  <= r_fourth;
            o_np_samples     <= r_fourth_cnt;
            o_heart_total    <= r_hr_sum;
            o_heart_samples  <= r_hr_cnt;
            o_climbed_dm     <= r_climb;
        end
    end

    assign o_out_valid = r_out_valid;

`include "ride_stats_accumulator_macros.svh"
    `RSA_ASSERT_NEXT(a_acc_busy, i_clk, i_rst_n, w_acc, r_busy)
    `RSA_ASSERT_IMPLIES(a_start_idle, i_clk, i_rst_n, w_start, !w_eng.busy)
    `RSA_ASSERT_IMPLIES(a_done_busy, i_clk, i_rst_n, w_eng.done, r_busy && !w_publish)
    `RSA_ASSERT_NEXT(a_pub_valid, i_clk, i_rst_n, w_publish, o_out_valid && !r_busy)

endmodule
